// ----- rtl/cdq_pkg.sv -----
package cdq_pkg;

    localparam int CDQ_CLASS_DEPTH = 32;
    localparam int CDQ_VALUE_WIDTH = 32;
    localparam int SEQ_W           = 7;
    localparam int IN_W            = 32;
    localparam int OUT_W           = 32;

    typedef enum logic [2:0] {
        OP_ADD       = 3'd0,
        OP_DRAIN_ALL = 3'd1,
        OP_DRAIN_DOG = 3'd2,
        OP_DRAIN_CAT = 3'd3,
        OP_Q_BOTH    = 3'd4,
        OP_Q_DOG     = 3'd5,
        OP_Q_CAT     = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        KIND_DOG    = 2'd0,
        KIND_CAT    = 2'd1,
        KIND_ANSWER = 2'd2,
        KIND_REJECT = 2'd3
    } t_kind;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_ctrl;

    typedef struct packed {
        logic empty;
        logic full;
        logic single;
    } t_fifo_stat;

endpackage

// ----- rtl/cdq_if.sv -----
interface cdq_in_if
    import cdq_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [2:0]             operation;
    logic                   is_cat;
    logic signed [IN_W-1:0] item_value;

    modport source (output valid, output operation, output is_cat, output item_value,
                    input ready);
    modport sink   (input valid, input operation, input is_cat, input item_value,
                    output ready);
endinterface

interface cdq_out_if
    import cdq_pkg::*;
();
    logic                    valid;
    logic                    ready;
    t_kind                   result_kind;
    logic signed [OUT_W-1:0] out_value;
    logic                    answer_yes;
    logic                    last_of_run;

    modport source (output valid, output result_kind, output out_value,
                    output answer_yes, output last_of_run, input ready);
    modport sink   (input valid, input result_kind, input out_value,
                    input answer_yes, input last_of_run, output ready);
endinterface

// ----- rtl/cdq_class_fifo.sv -----
module cdq_class_fifo
    import cdq_pkg::*;
#(
    parameter int DEPTH   = CDQ_CLASS_DEPTH,
    parameter int ENTRY_W = CDQ_VALUE_WIDTH + SEQ_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_fifo_ctrl         i_ctrl,
    input  logic [ENTRY_W-1:0] i_wdata,
    output t_fifo_stat         o_stat,
    output logic [ENTRY_W-1:0] o_head_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_head_entry;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [PTR_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]   r_count, n_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_head  = i_ctrl.pop  ? ptr_inc(r_head) : r_head;
        n_tail  = i_ctrl.push ? ptr_inc(r_tail) : r_tail;
        n_count = r_count;
        if (i_ctrl.push && !i_ctrl.pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_ctrl.push && i_ctrl.pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // The read port always fetches the entry that will be at the head next
    // cycle; a write to that same entry is forwarded so the head is never stale.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[r_tail] <= i_wdata;
        end
        if (i_ctrl.push && (r_tail == n_head)) begin
            r_head_entry <= i_wdata;
        end else begin
            r_head_entry <= r_mem[n_head];
        end
    end

    assign o_stat.empty  = (r_count == '0);
    assign o_stat.full   = (r_count == FULL_CNT);
    assign o_stat.single = (r_count == ONE_CNT);
    assign o_head_entry  = r_head_entry;

endmodule

// ----- rtl/two_class_age_ordered_fifo_unit.sv -----
// Two age-ordered queues, dog and cat, each held in its own simple dual-port
// synchronous memory, with every stored item tagged by a 7-bit arrival number.
// Adds and queries are handled as each input beat is accepted. A drain starts
// from idle and then emits one beat each time the output register can load;
// each class memory is read a cycle ahead, so the head entry is always ready
// for the output register. No new input is taken until a drain has finished.
// Adding to a full class drops the item and returns a rejected beat. While a
// result waits in the output register for the sink, no new input is taken.
module two_class_age_ordered_fifo_unit
    import cdq_pkg::*;
#(
    parameter int CLASS_DEPTH = CDQ_CLASS_DEPTH,
    parameter int VALUE_WIDTH = CDQ_VALUE_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cdq_in_if.sink    i_in,
    cdq_out_if.source o_out
);

    localparam int ENTRY_W = VALUE_WIDTH + SEQ_W;
    localparam int EXT_W   = 64;

    t_state r_state, n_state;
    t_op    r_op;
    logic [SEQ_W-1:0] r_seq;

    logic                    r_out_valid;
    t_kind                   r_kind;
    logic signed [OUT_W-1:0] r_value;
    logic                    r_yes;
    logic                    r_last;

    t_fifo_ctrl dog_ctrl, cat_ctrl;
    t_fifo_stat dog_stat, cat_stat;
    logic [ENTRY_W-1:0] dog_entry, cat_entry, wdata;
    logic [EXT_W-1:0]   in_ext, dog_ext, cat_ext;
    logic [SEQ_W-1:0]   tag_diff;
    logic               take_dog;
    logic               can_load, accept, start_drain, seq_inc;
    logic               load, ld_yes, ld_last;
    t_kind              ld_kind;
    logic [OUT_W-1:0]   ld_value;

    cdq_class_fifo #(.DEPTH(CLASS_DEPTH), .ENTRY_W(ENTRY_W)) u_dog (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (dog_ctrl),
        .i_wdata      (wdata),
        .o_stat       (dog_stat),
        .o_head_entry (dog_entry)
    );

    cdq_class_fifo #(.DEPTH(CLASS_DEPTH), .ENTRY_W(ENTRY_W)) u_cat (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (cat_ctrl),
        .i_wdata      (wdata),
        .o_stat       (cat_stat),
        .o_head_entry (cat_entry)
    );

    assign in_ext = {{(EXT_W - IN_W){1'b0}}, i_in.item_value};
    assign wdata  = {r_seq, in_ext[VALUE_WIDTH-1:0]};

    assign dog_ext = {{(EXT_W - VALUE_WIDTH){dog_entry[VALUE_WIDTH-1]}},
                      dog_entry[VALUE_WIDTH-1:0]};
    assign cat_ext = {{(EXT_W - VALUE_WIDTH){cat_entry[VALUE_WIDTH-1]}},
                      cat_entry[VALUE_WIDTH-1:0]};

    // Tags wrap, so the dog head is older when the modular difference is negative.
    assign tag_diff = dog_entry[ENTRY_W-1 -: SEQ_W] - cat_entry[ENTRY_W-1 -: SEQ_W];
    assign take_dog = cat_stat.empty || (!dog_stat.empty && tag_diff[SEQ_W-1]);

    assign can_load = !r_out_valid || o_out.ready;
    assign accept   = i_in.valid && i_in.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start_drain) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (load && ld_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready  = 1'b0;
        dog_ctrl    = '0;
        cat_ctrl    = '0;
        start_drain = 1'b0;
        seq_inc     = 1'b0;
        load        = 1'b0;
        ld_kind     = KIND_DOG;
        ld_value    = '0;
        ld_yes      = 1'b0;
        ld_last     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                i_in.ready = can_load;
                if (i_in.valid && can_load) begin
                    unique case (t_op'(i_in.operation))
                        OP_ADD: begin
                            if (i_in.is_cat ? cat_stat.full : dog_stat.full) begin
                                load    = 1'b1;
                                ld_kind = KIND_REJECT;
                                ld_last = 1'b1;
                            end else begin
                                cat_ctrl.push = i_in.is_cat;
                                dog_ctrl.push = !i_in.is_cat;
                                seq_inc       = 1'b1;
                            end
                        end
                        OP_DRAIN_ALL: start_drain = !(dog_stat.empty && cat_stat.empty);
                        OP_DRAIN_DOG: start_drain = !dog_stat.empty;
                        OP_DRAIN_CAT: start_drain = !cat_stat.empty;
                        OP_Q_BOTH: begin
                            load    = 1'b1;
                            ld_kind = KIND_ANSWER;
                            ld_yes  = dog_stat.empty && cat_stat.empty;
                            ld_last = 1'b1;
                        end
                        OP_Q_DOG: begin
                            load    = 1'b1;
                            ld_kind = KIND_ANSWER;
                            ld_yes  = dog_stat.empty;
                            ld_last = 1'b1;
                        end
                        OP_Q_CAT: begin
                            load    = 1'b1;
                            ld_kind = KIND_ANSWER;
                            ld_yes  = cat_stat.empty;
                            ld_last = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DRAIN: begin
                if (can_load) begin
                    load = 1'b1;
                    case (r_op)
                        OP_DRAIN_DOG: begin
                            dog_ctrl.pop = 1'b1;
                            ld_kind      = KIND_DOG;
                            ld_value     = dog_ext[OUT_W-1:0];
                            ld_last      = dog_stat.single;
                        end
                        OP_DRAIN_CAT: begin
                            cat_ctrl.pop = 1'b1;
                            ld_kind      = KIND_CAT;
                            ld_value     = cat_ext[OUT_W-1:0];
                            ld_last      = cat_stat.single;
                        end
                        default: begin
                            dog_ctrl.pop = take_dog;
                            cat_ctrl.pop = !take_dog;
                            ld_kind      = take_dog ? KIND_DOG : KIND_CAT;
                            ld_value     = take_dog ? dog_ext[OUT_W-1:0] : cat_ext[OUT_W-1:0];
                            ld_last      = (dog_stat.single && cat_stat.empty)
                                        || (cat_stat.single && dog_stat.empty);
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seq       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (seq_inc) begin
                r_seq <= r_seq + 1'b1;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= t_op'(i_in.operation);
        end
        if (load) begin
            r_kind  <= ld_kind;
            r_value <= ld_value;
            r_yes   <= ld_yes;
            r_last  <= ld_last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.result_kind = r_kind;
    assign o_out.out_value   = r_value;
    assign o_out.answer_yes  = r_yes;
    assign o_out.last_of_run = r_last;

endmodule
